>>> hdl/tlb_pkg.sv
// Package for the ternary layer binarize unit.
// Holds command codes, field widths and the accumulator limit.
// No dependencies.
package tlb_pkg;

  localparam int CMD_W    = 2;
  localparam int IDX_W    = 10;
  localparam int WEIGHT_W = 2;
  localparam int SUM_W    = 12;

  typedef logic [CMD_W-1:0]           cmd_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  localparam cmd_t CMD_LOAD   = 2'd0;
  localparam cmd_t CMD_WEIGHT = 2'd1;
  localparam cmd_t CMD_SWAP   = 2'd2;

  // weight codes: 01 is +1, 00 is 0, 11 and 10 both count as -1
  localparam weight_t W_ZERO = 2'sb00;
  localparam weight_t W_POS  = 2'sb01;

  localparam sum_t ACC_LIMIT     = 12'sd1024;
  localparam sum_t ACC_LIMIT_NEG = -12'sd1024;

endpackage

>>> hdl/ternary_layer_binarize_unit.sv
// Top level of the ternary layer binarize unit.
// Depends on tlb_pkg and tlb_ram (two activation stores).
//
// Channel   Dir  Handshake            Beat payload
// --------  ---  -------------------  ------------------------------------------
// input     in   in_valid / in_stall  cmd, elem_index, act_bit, weight, row_last
// output    out  out_valid/out_stall  row_number, out_bit, row_sum
//
// Steps: load, swap and unknown commands finish as the beat is taken. A
//   weight beat reads the activation bit from the current store as it is
//   taken, then accumulates (and, on the last weight of a row, writes the
//   clipped bit into the other store and loads the output register).
// Reset: rst (synchronous) clears the store select, accumulator, row
//   counter and output valid. Store contents are not cleared.
// Stalls: the output register holds one result; the next input beat is
//   taken while it waits. A row end that finds the output still full and
//   stalled waits in the accumulate cycle until it drains.
module ternary_layer_binarize_unit
  import tlb_pkg::*;
#(
  parameter int VECTOR_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           cmd,
  input  logic [IDX_W-1:0]           elem_index,
  input  logic                       act_bit,
  input  logic signed [WEIGHT_W-1:0] weight,
  input  logic                       row_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [IDX_W-1:0]           row_number,
  output logic                       out_bit,
  output logic signed [SUM_W-1:0]    row_sum
);

  localparam int AW = $clog2(VECTOR_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ACC  = 1'b1;

  // Fold a 10-bit index into the store depth (restoring reduction by
  // shifted copies of the depth; all compares are against constants).
  function automatic logic [AW-1:0] wrap_index(input idx_t v);
    logic [31:0] r;
    r = {{(32-IDX_W){1'b0}}, v};
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (((32'(VECTOR_DEPTH) << k) <= 32'd1023) && (r >= (32'(VECTOR_DEPTH) << k))) begin
        r = r - (32'(VECTOR_DEPTH) << k);
      end
    end
    return r[AW-1:0];
  endfunction

  // control state
  logic       state;
  logic       store_select;   // 0: store a is current
  sum_t       accumulator;
  idx_t       row_counter;

  // captured weight beat
  weight_t    weight_q;
  logic       last_q;

  // datapath
  logic          accept;
  logic [AW-1:0] idx_wrap;
  logic [AW-1:0] row_slot;
  logic          rd_a;
  logic          rd_b;
  logic          rd_bit;
  logic          rd_en;
  sum_t          delta;
  sum_t          sum_raw;
  sum_t          sum_sat;
  logic          bit_new;
  logic          out_free;
  logic          finish;
  logic          row_wr;
  logic          load_wr;
  logic          we_a;
  logic          we_b;
  logic [AW-1:0] waddr;
  logic          wdata;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_wrap = wrap_index(elem_index);
  assign row_slot = wrap_index(row_counter);
  assign rd_en    = accept && (cmd == CMD_WEIGHT);
  assign rd_bit   = store_select ? rd_b : rd_a;

  always_comb begin
    // weight times (+1 for a set bit, -1 for a clear bit)
    if (weight_q == W_ZERO) begin
      delta = '0;
    end else if ((weight_q == W_POS) == rd_bit) begin
      delta = 12'sd1;
    end else begin
      delta = -12'sd1;
    end
    sum_raw = accumulator + delta;
    if (sum_raw > ACC_LIMIT) begin
      sum_sat = ACC_LIMIT;
    end else if (sum_raw < ACC_LIMIT_NEG) begin
      sum_sat = ACC_LIMIT_NEG;
    end else begin
      sum_sat = sum_raw;
    end
    bit_new = (sum_sat > 12'sd0);
  end

  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == ST_ACC) && (!last_q || out_free);
  assign row_wr   = (state == ST_ACC) && last_q && out_free;
  assign load_wr  = accept && (cmd == CMD_LOAD);

  // loads go to the current store, row bits to the other one
  assign we_a  = (load_wr && !store_select) || (row_wr && store_select);
  assign we_b  = (load_wr && store_select) || (row_wr && !store_select);
  assign waddr = row_wr ? row_slot : idx_wrap;
  assign wdata = row_wr ? bit_new : act_bit;

  tlb_ram #(
    .WIDTH(1),
    .DEPTH(VECTOR_DEPTH)
  ) u_store_a (
    .clk  (clk),
    .we   (we_a),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(idx_wrap),
    .rdata(rd_a)
  );

  tlb_ram #(
    .WIDTH(1),
    .DEPTH(VECTOR_DEPTH)
  ) u_store_b (
    .clk  (clk),
    .we   (we_b),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(idx_wrap),
    .rdata(rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      store_select <= 1'b0;
      accumulator  <= '0;
      row_counter  <= '0;
      out_valid    <= 1'b0;
    end else begin
      // a finished row refills the output register, else a taken beat empties it
      if (finish && last_q) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_WEIGHT: begin
                weight_q <= weight;
                last_q   <= row_last;
                state    <= ST_ACC;
              end
              CMD_SWAP: begin
                store_select <= ~store_select;
                row_counter  <= '0;
              end
              default: begin
                // load is handled by the store write port; code 3 is a no-op
              end
            endcase
          end
        end
        ST_ACC: begin
          if (finish) begin
            state <= ST_IDLE;
            if (last_q) begin
              row_number  <= row_counter;
              out_bit     <= bit_new;
              row_sum     <= sum_sat;
              accumulator <= '0;
              row_counter <= row_counter + 1'b1;
            end else begin
              accumulator <= sum_sat;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/tlb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// Read data updates only on a read enable. No dependencies.
module tlb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/ternary_layer_binarize_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for ternary_layer_binarize_unit: drives load, weight and swap beats
// and checks every finished row against a tracker of stores, accumulator and row counter.
// Depends on tlb_pkg and the unit's RTL.
module ternary_layer_binarize_unit_test;
  import tlb_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int ACC_MAX      = int'(ACC_LIMIT);
  localparam int RAND_ITEMS   = 1000;
  localparam int QUIET_TAIL   = 150;   // last random beats run with no idling on either side
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_SHOWN    = 30;
  localparam int RUN_LIMIT_NS = 1_000_000;

  // codes the package does not name
  localparam cmd_t    CMD_UNUSED = 2'd3;   // ignored by the unit
  localparam weight_t W_NEG      = 2'sb11; // -1
  localparam weight_t W_NEG2     = 2'sb10; // -2, counts as -1

  typedef struct packed {
    cmd_t    cmd;
    idx_t    elem_index;
    logic    act_bit;
    weight_t weight;
    logic    row_last;
  } beat_t;

  typedef struct packed {
    idx_t row_no;
    logic clipped;
    sum_t total;
  } row_result_t;

  // Tracks both activation stores, which one is current, the running row sum and the
  // row counter; every finished row queues the result the unit must produce.
  class layer_tracker;
    logic        store_bits [2][DEPTH];
    bit          written    [2][DEPTH];
    int          wr_count   [2];
    bit          cur_sel;
    int          acc;
    idx_t        row_ctr;
    row_result_t expected_rows [$];
    int          errors, beats, ignored, swaps, clamps, wraps, rows_checked;

    function void mark(bit sel, int unsigned i, logic v);
      if (!written[sel][i]) wr_count[sel]++;
      written[sel][i]    = 1'b1;
      store_bits[sel][i] = v;
    endfunction

    function void note_beat(beat_t b);
      int          step;
      int          x;
      int unsigned i;
      row_result_t r;
      beats++;
      i = b.elem_index % DEPTH;
      case (b.cmd)
        CMD_LOAD: mark(cur_sel, i, b.act_bit);
        CMD_SWAP: begin
          // only stores and row counter move; a partial sum carries on
          cur_sel = !cur_sel;
          row_ctr = '0;
          swaps++;
        end
        CMD_WEIGHT: begin
          if (b.weight == W_POS) step = 1;
          else if (b.weight == W_ZERO) step = 0;
          else step = -1;
          x = store_bits[cur_sel][i] ? 1 : -1;
          acc += step * x;
          if (acc > ACC_MAX) begin
            acc = ACC_MAX;
            clamps++;
          end
          if (acc < -ACC_MAX) begin
            acc = -ACC_MAX;
            clamps++;
          end
          if (b.row_last) begin
            r.row_no  = row_ctr;
            r.clipped = (acc >= 1);
            r.total   = sum_t'(acc);
            mark(!cur_sel, row_ctr % DEPTH, r.clipped);
            expected_rows.push_back(r);
            acc = 0;
            if (row_ctr == '1) wraps++;
            row_ctr++;
          end
        end
        default: ignored++;
      endcase
    endfunction

    task flag_mismatch(string msg);
      errors++;
      if (errors <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_row(idx_t rn, logic ob, sum_t rs);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        flag_mismatch($sformatf("row beat %0d/%0b/%0d with none pending", rn, ob, rs));
        return;
      end
      want = expected_rows.pop_front();
      rows_checked++;
      if (rn !== want.row_no)
        flag_mismatch($sformatf("row_number %0d, want %0d", rn, want.row_no));
      if (ob !== want.clipped)
        flag_mismatch($sformatf("row %0d out_bit %0b, want %0b", want.row_no, ob, want.clipped));
      if (rs !== want.total)
        flag_mismatch($sformatf("row %0d row_sum %0d, want %0d", want.row_no, rs, want.total));
    endtask
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    in_valid;
  logic    in_stall;
  cmd_t    cmd;
  idx_t    elem_index;
  logic    act_bit;
  weight_t weight;
  logic    row_last;
  logic    out_valid;
  logic    out_stall;
  idx_t    row_number;
  logic    out_bit;
  sum_t    row_sum;

  layer_tracker sb;

  // idling knobs for sender and receiver
  bit quiet    = 1'b0;  // no random idling on either side
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off
  int idle_pct = 25;
  int rx_stall_pct = 25;

  ternary_layer_binarize_unit #(
    .VECTOR_DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .elem_index(elem_index),
    .act_bit   (act_bit),
    .weight    (weight),
    .row_last  (row_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_number(row_number),
    .out_bit   (out_bit),
    .row_sum   (row_sum)
  );

  always #1 clk = ~clk;

  // Beat constructors. Fields a command ignores are left random.
  function automatic beat_t make_beat(cmd_t c, idx_t i, logic a, weight_t w, logic l);
    beat_t b;
    b.cmd        = c;
    b.elem_index = i;
    b.act_bit    = a;
    b.weight     = w;
    b.row_last   = l;
    return b;
  endfunction

  function automatic beat_t junk_beat(cmd_t c);
    return make_beat(c, idx_t'($urandom), 1'($urandom), weight_t'($urandom), 1'($urandom));
  endfunction

  // A written entry of the current store. Entries never written must not be read.
  function automatic idx_t pick_written();
    idx_t i;
    i = idx_t'($urandom);
    repeat (DEPTH) begin
      if (sb.written[sb.cur_sel][i]) return i;
      i++;
    end
    return i;
  endfunction

  // Weight beat whose contribution to the row sum is +1 (want > 0) or -1.
  function automatic beat_t contrib_beat(int want, logic end_row);
    beat_t b;
    b = junk_beat(CMD_WEIGHT);
    b.elem_index = pick_written();
    b.row_last   = end_row;
    if ((want > 0) == (sb.store_bits[sb.cur_sel][b.elem_index] == 1'b1)) b.weight = W_POS;
    else b.weight = $urandom_range(0, 1) ? W_NEG : W_NEG2;
    return b;
  endfunction

  // Offer one beat, after an optional idle burst, and hold it until taken.
  task automatic send_beat(beat_t b);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= b.cmd;
    elem_index <= b.elem_index;
    act_bit    <= b.act_bit;
    weight     <= b.weight;
    row_last   <= b.row_last;
    do @(posedge clk); while (in_stall);
    sb.note_beat(b);
  endtask

  // Receiver stall pattern: long hold-off on request, else short random bursts.
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < rx_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Result beats are sampled at the edge that accepts them.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_row(row_number, out_bit, row_sum);
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("ternary_layer_binarize_unit_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    beat_t       b;
    int          counted;
    int unsigned r;
    sb = new();
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    cmd        <= CMD_LOAD;
    elem_index <= '0;
    act_bit    <= 1'b0;
    weight     <= W_ZERO;
    row_last   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: index extremes and alternating patterns, every weight code,
    // a sum of exactly 1 and of 0, an ignored command, a swap mid-row.
    send_beat(make_beat(CMD_LOAD, 10'd0, 1'b0, W_NEG, 1'b1));
    send_beat(make_beat(CMD_LOAD, 10'd1023, 1'b1, W_POS, 1'b1));
    send_beat(make_beat(CMD_LOAD, 10'h200, 1'b1, W_NEG2, 1'b0));
    send_beat(make_beat(CMD_LOAD, 10'h155, 1'b0, W_ZERO, 1'b1));
    send_beat(make_beat(CMD_LOAD, 10'h2AA, 1'b1, W_NEG, 1'b0));
    send_beat(make_beat(CMD_WEIGHT, 10'd1023, 1'b0, W_POS, 1'b0));
    send_beat(make_beat(CMD_WEIGHT, 10'd0, 1'b1, W_NEG, 1'b1));    // sum 2
    send_beat(make_beat(CMD_WEIGHT, 10'h200, 1'b1, W_ZERO, 1'b1)); // sum 0
    send_beat(make_beat(CMD_WEIGHT, 10'd1023, 1'b0, W_NEG2, 1'b1)); // -2 code, sum -1
    send_beat(make_beat(CMD_WEIGHT, 10'h2AA, 1'b0, W_POS, 1'b1));  // sum exactly 1
    send_beat(make_beat(CMD_WEIGHT, 10'h155, 1'b1, W_NEG, 1'b0));  // partial +1
    send_beat(make_beat(CMD_UNUSED, 10'h3FF, 1'b1, W_NEG, 1'b1));
    send_beat(make_beat(CMD_SWAP, 10'h3FF, 1'b1, W_NEG2, 1'b1));   // partial sum survives
    send_beat(make_beat(CMD_WEIGHT, 10'd0, 1'b0, W_POS, 1'b1));
    send_beat(make_beat(CMD_WEIGHT, 10'd3, 1'b0, W_NEG, 1'b1));
    send_beat(make_beat(CMD_LOAD, 10'd1023, 1'b0, W_POS, 1'b1));
    send_beat(make_beat(CMD_WEIGHT, 10'd1023, 1'b1, W_POS, 1'b1));
    send_beat(make_beat(CMD_WEIGHT, 10'd2, 1'b1, W_NEG2, 1'b1));
    send_beat(make_beat(CMD_SWAP, 10'd0, 1'b0, W_ZERO, 1'b0));

    // Receiver holds off while the sender keeps offering; the output register fills,
    // a row end waits in accumulate, and the input side stalls.
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 48; k++)
      send_beat(contrib_beat($urandom_range(0, 1) ? 1 : -1, k[0]));
    quiet = 1'b0;

    // Random layers: mostly loads and weights on written entries, some swaps (often
    // mid-row), a little ignored noise. Idling comes and goes in stretches.
    counted = 0;
    while (counted < RAND_ITEMS) begin
      idle_pct     = ((counted / 80) % 3 == 2) ? 0 : 30;
      rx_stall_pct = ((counted / 70) % 3 == 1) ? 0 : 30;
      quiet        = (counted >= RAND_ITEMS - QUIET_TAIL);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        b = junk_beat(CMD_UNUSED);
      end else if (r < 7 && sb.wr_count[!sb.cur_sel] != 0) begin
        b = junk_beat(CMD_SWAP);
      end else if (r < 27 || sb.wr_count[sb.cur_sel] == 0) begin
        b = junk_beat(CMD_LOAD);
      end else begin
        b = junk_beat(CMD_WEIGHT);
        b.elem_index = pick_written();
        b.row_last   = ($urandom_range(0, 7) == 0);
      end
      send_beat(b);
      if (b.cmd != CMD_UNUSED) counted++;
    end
    in_valid <= 1'b0;

    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d input beats (%0d ignored), %0d rows checked, %0d store swaps",
             sb.beats, sb.ignored, sb.rows_checked, sb.swaps);
    $display("run: %0d accumulator clamps, %0d row counter rollovers, %0d mismatches",
             sb.clamps, sb.wraps, sb.errors);
    if (sb.errors == 0) begin
      $display("ternary_layer_binarize_unit_test: done, clean");
    end else begin
      $display("ternary_layer_binarize_unit_test: done, errors");
    end
    $finish;
  end

endmodule
